>>> hw/rtl/ctrgb_pkg.sv
`default_nettype none

package ctrgb_pkg;

    // output format
    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 22;

    // temperature range
    localparam int IN_W = 16;
    localparam int TC_W = 14;
    localparam int SQ_W = 2 * TC_W;
    localparam logic [TC_W-1:0] T_MIN = 14'd1000;
    localparam logic [TC_W-1:0] T_MAX = 14'd15000;

    // polynomial coefficient formats, all scaled by 2^48
    localparam int POLY_SHIFT = 48;
    localparam int C0_W       = 48;
    localparam int LC_W       = 40;
    localparam int QC_W       = 28;
    localparam int LP_W       = LC_W + TC_W;
    localparam int QP_W       = QC_W + SQ_W;
    localparam int POLY_W     = 56;
    localparam logic [POLY_W-1:0] POLY_ONE = POLY_W'(1) << POLY_SHIFT;

    // decimal divisors
    localparam logic [127:0] DEC_1E9  = 128'd1000000000;
    localparam logic [127:0] DEC_1E12 = 128'd1000000000000;
    localparam logic [127:0] DEC_1E13 = 128'd10000000000000;
    localparam logic [127:0] DEC_1E15 = 128'd1000000000000000;
    localparam logic [127:0] DEC_1E16 = 128'd10000000000000000;
    localparam logic [127:0] DEC_1E7  = 128'd10000000;

    // u numerator and denominator
    localparam logic [C0_W-1:0] NU_C0 =
        C0_W'((((128'd860117757 << (POLY_SHIFT + 1)) / DEC_1E9) + 128'd1) >> 1);
    localparam logic [LC_W-1:0] NU_C1 =
        LC_W'((((128'd154118254 << (POLY_SHIFT + 1)) / DEC_1E12) + 128'd1) >> 1);
    localparam logic [QC_W-1:0] NU_C2 =
        QC_W'((((128'd128641212 << (POLY_SHIFT + 1)) / DEC_1E15) + 128'd1) >> 1);
    localparam logic [LC_W-1:0] DU_C1 =
        LC_W'((((128'd842420235 << (POLY_SHIFT + 1)) / DEC_1E12) + 128'd1) >> 1);
    localparam logic [QC_W-1:0] DU_C2 =
        QC_W'((((128'd708145163 << (POLY_SHIFT + 1)) / DEC_1E15) + 128'd1) >> 1);

    // v numerator and denominator
    localparam logic [C0_W-1:0] NV_C0 =
        C0_W'((((128'd317398726 << (POLY_SHIFT + 1)) / DEC_1E9) + 128'd1) >> 1);
    localparam logic [LC_W-1:0] NV_C1 =
        LC_W'((((128'd422806245 << (POLY_SHIFT + 1)) / DEC_1E13) + 128'd1) >> 1);
    localparam logic [QC_W-1:0] NV_C2 =
        QC_W'((((128'd420481691 << (POLY_SHIFT + 1)) / DEC_1E16) + 128'd1) >> 1);
    localparam logic [LC_W-1:0] DV_C1 =
        LC_W'((((128'd289741816 << (POLY_SHIFT + 1)) / DEC_1E13) + 128'd1) >> 1);
    localparam logic [QC_W-1:0] DV_C2 =
        QC_W'((((128'd161456053 << (POLY_SHIFT + 1)) / DEC_1E15) + 128'd1) >> 1);

    // divider: floor(num * 2^32 / den), quotient below 2^34
    localparam int UV_SHIFT  = 32;
    localparam int DIV_W     = 56;
    localparam int DIV_STEPS = 34;
    localparam int LO_W      = DIV_STEPS - UV_SHIFT;

    // xyz formats
    localparam int ZN_W  = 38;
    localparam int XYZ_W = 36;

    // matrix in signed Q.24
    localparam int MAT_SHIFT = 24;
    localparam int MC_W      = 28;
    localparam int ACC_W     = 64;
    localparam int RND_SH    = 2 * UV_SHIFT - UV_SHIFT + MAT_SHIFT - FRAC_BITS;

    localparam logic [MC_W-1:0] MAT_M0 =
        MC_W'((((128'd32404542 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);
    localparam logic [MC_W-1:0] MAT_M1 =
        MC_W'((((128'd15371385 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);
    localparam logic [MC_W-1:0] MAT_M2 =
        MC_W'((((128'd4985314 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);
    localparam logic [MC_W-1:0] MAT_M3 =
        MC_W'((((128'd9692660 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);
    localparam logic [MC_W-1:0] MAT_M4 =
        MC_W'((((128'd18760108 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);
    localparam logic [MC_W-1:0] MAT_M5 =
        MC_W'((((128'd415560 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);
    localparam logic [MC_W-1:0] MAT_M6 =
        MC_W'((((128'd556434 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);
    localparam logic [MC_W-1:0] MAT_M7 =
        MC_W'((((128'd2040259 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);
    localparam logic [MC_W-1:0] MAT_M8 =
        MC_W'((((128'd10572252 << (MAT_SHIFT + 1)) / DEC_1E7) + 128'd1) >> 1);

    // row major: red, green, blue times x, y, z
    localparam logic signed [MC_W-1:0] MAT [9] = '{
        signed'(MAT_M0), -signed'(MAT_M1), -signed'(MAT_M2),
        -signed'(MAT_M3), signed'(MAT_M4), signed'(MAT_M5),
        signed'(MAT_M6), -signed'(MAT_M7), signed'(MAT_M8)
    };

endpackage

`default_nettype wire

>>> hw/rtl/color_temperature_to_rgb_unit.sv
// pipeline from input transfer to result: 3 polynomial, 34 u/v divide,
// 1 xyz setup, 34 x/z divide, 3 matrix and rounding stages
// throughput: one temperature per cycle while the pipeline advances; one restoring quotient bit per stage
// the whole pipeline advances when the output register is empty or being taken
// reset clears every valid bit; data registers are not reset
`default_nettype none

module color_temperature_to_rgb_unit
    import ctrgb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [IN_W-1:0]   s_temperature_kelvin,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [OUT_W-1:0]       m_red,
    output logic [OUT_W-1:0]       m_green,
    output logic [OUT_W-1:0]       m_blue
);

    logic                 ce;
    logic                 poly_valid;
    logic [POLY_W-1:0]    nu, du, nv, dv;
    logic                 uv_valid;
    logic [DIV_STEPS-1:0] uq, vq;
    logic                 xyz_valid_reg;
    logic [DIV_W-1:0]     xnum_reg, xnum_next;
    logic [DIV_W-1:0]     znum_reg, znum_next;
    logic [DIV_W-1:0]     den2_reg, den2_next;
    logic                 zneg_reg, zneg_next;
    logic [ZN_W-1:0]      zn;
    logic                 xz_valid;
    logic [DIV_STEPS-1:0] xq, zmag;
    logic                 zneg_out;

    // global advance: output register free or being drained
    assign ce      = m_ready | ~m_valid;
    assign s_ready = ce;

    ctrgb_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_temp   (s_temperature_kelvin),
        .out_valid (poly_valid),
        .nu        (nu),
        .du        (du),
        .nv        (nv),
        .dv        (dv)
    );

    // u and v
    ctrgb_div u_div_u (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (poly_valid),
        .in_tag    (1'b0),
        .num       (nu),
        .den       (du),
        .out_valid (uv_valid),
        .out_tag   (),
        .quo       (uq)
    );

    ctrgb_div u_div_v (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (poly_valid),
        .in_tag    (1'b0),
        .num       (nv),
        .den       (dv),
        .out_valid (),
        .out_tag   (),
        .quo       (vq)
    );

    // 3u, 2v and the signed z numerator 4 - u - 10v
    always_comb begin
        xnum_next = DIV_W'({uq, 1'b0}) + DIV_W'(uq);
        den2_next = DIV_W'({vq, 1'b0});
        zn        = (ZN_W'(4) << UV_SHIFT) - ZN_W'(uq)
                  - ZN_W'({vq, 3'b000}) - ZN_W'({vq, 1'b0});
        zneg_next = zn[ZN_W-1];
        znum_next = zneg_next ? DIV_W'(ZN_W'(0) - zn) : DIV_W'(zn);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xyz_valid_reg <= 1'b0;
        end else if (ce) begin
            xyz_valid_reg <= uv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            xnum_reg <= xnum_next;
            znum_reg <= znum_next;
            den2_reg <= den2_next;
            zneg_reg <= zneg_next;
        end
    end

    // x and z
    ctrgb_div u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (xyz_valid_reg),
        .in_tag    (1'b0),
        .num       (xnum_reg),
        .den       (den2_reg),
        .out_valid (),
        .out_tag   (),
        .quo       (xq)
    );

    ctrgb_div u_div_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (xyz_valid_reg),
        .in_tag    (zneg_reg),
        .num       (znum_reg),
        .den       (den2_reg),
        .out_valid (xz_valid),
        .out_tag   (zneg_out),
        .quo       (zmag)
    );

    ctrgb_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (xz_valid),
        .xq        (xq),
        .zmag      (zmag),
        .zneg      (zneg_out),
        .out_valid (m_valid),
        .red       (m_red),
        .green     (m_green),
        .blue      (m_blue)
    );

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // clamped temperatures give u in [0, 1) and v in (0, 1)
    a_uv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        uv_valid |-> (vq != '0) && (uq[DIV_STEPS-1:UV_SHIFT] == '0)
                     && (vq[DIV_STEPS-1:UV_SHIFT] == '0))
        else $error("u or v out of range");

    // an advancing u/v item reaches the xyz stage
    a_xyz_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        uv_valid && ce |=> xyz_valid_reg)
        else $error("item lost between divide stages");

endmodule

`default_nettype wire

>>> hw/rtl/ctrgb_poly.sv
`default_nettype none

module ctrgb_poly
    import ctrgb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              ce,
    input  wire logic              in_valid,
    input  wire logic [IN_W-1:0]   in_temp,
    output logic                   out_valid,
    output logic [POLY_W-1:0]      nu,
    output logic [POLY_W-1:0]      du,
    output logic [POLY_W-1:0]      nv,
    output logic [POLY_W-1:0]      dv
);

    logic            vld1_reg, vld2_reg, vld3_reg;
    logic [TC_W-1:0] t_reg, t_next;
    logic [SQ_W-1:0] sq_reg, sq_next;
    logic [LP_W-1:0] nu1_reg, du1_reg, nv1_reg, dv1_reg;
    logic [QP_W-1:0] nu2_reg, du2_reg, nv2_reg, dv2_reg;
    logic [POLY_W-1:0] nu_reg, du_reg, nv_reg, dv_reg;

    // clamp and square
    always_comb begin
        if (in_temp < IN_W'(T_MIN)) begin
            t_next = T_MIN;
        end else if (in_temp > IN_W'(T_MAX)) begin
            t_next = T_MAX;
        end else begin
            t_next = in_temp[TC_W-1:0];
        end
        sq_next = SQ_W'(t_next) * SQ_W'(t_next);
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (ce) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // clamp, terms, sums
    always_ff @(posedge aclk) begin
        if (ce) begin
            t_reg   <= t_next;
            sq_reg  <= sq_next;
            nu1_reg <= LP_W'(NU_C1) * LP_W'(t_reg);
            du1_reg <= LP_W'(DU_C1) * LP_W'(t_reg);
            nv1_reg <= LP_W'(NV_C1) * LP_W'(t_reg);
            dv1_reg <= LP_W'(DV_C1) * LP_W'(t_reg);
            nu2_reg <= QP_W'(NU_C2) * QP_W'(sq_reg);
            du2_reg <= QP_W'(DU_C2) * QP_W'(sq_reg);
            nv2_reg <= QP_W'(NV_C2) * QP_W'(sq_reg);
            dv2_reg <= QP_W'(DV_C2) * QP_W'(sq_reg);
            nu_reg  <= POLY_W'(NU_C0) + POLY_W'(nu1_reg) + POLY_W'(nu2_reg);
            du_reg  <= POLY_ONE + POLY_W'(du1_reg) + POLY_W'(du2_reg);
            nv_reg  <= POLY_W'(NV_C0) + POLY_W'(nv1_reg) + POLY_W'(nv2_reg);
            dv_reg  <= POLY_ONE + POLY_W'(dv2_reg) - POLY_W'(dv1_reg);
        end
    end

    assign out_valid = vld3_reg;
    assign nu = nu_reg;
    assign du = du_reg;
    assign nv = nv_reg;
    assign dv = dv_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ctrgb_div.sv
`default_nettype none

module ctrgb_div
    import ctrgb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire logic                 in_tag,
    input  wire logic [DIV_W-1:0]     num,
    input  wire logic [DIV_W-1:0]     den,
    output logic                      out_valid,
    output logic                      out_tag,
    output logic [DIV_STEPS-1:0]      quo
);

    logic [DIV_W-1:0]     rem_reg [DIV_STEPS];
    logic [DIV_W-1:0]     den_reg [DIV_STEPS];
    logic [LO_W-1:0]      lo_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg [DIV_STEPS];
    logic                 vld_reg [DIV_STEPS];
    logic                 tag_reg [DIV_STEPS];

    // one restoring quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        logic [DIV_W-1:0]     rem_in, den_in, rem_next;
        logic [LO_W-1:0]      lo_in;
        logic [DIV_STEPS-1:0] quo_in;
        logic                 vld_in, tag_in;
        logic [DIV_W:0]       trial;
        logic [DIV_W+1:0]     diff;
        logic                 ge;

        if (i == 0) begin : g_first
            assign rem_in = num >> LO_W;
            assign lo_in  = num[LO_W-1:0];
            assign den_in = den;
            assign quo_in = '0;
            assign vld_in = in_valid;
            assign tag_in = in_tag;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign lo_in  = lo_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign vld_in = vld_reg[i-1];
            assign tag_in = tag_reg[i-1];
        end

        always_comb begin
            trial    = {rem_in, lo_in[LO_W-1]};
            diff     = {1'b0, trial} - {2'b00, den_in};
            ge       = ~diff[DIV_W+1];
            rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (ce) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i] <= rem_next;
                lo_reg[i]  <= lo_in << 1;
                den_reg[i] <= den_in;
                quo_reg[i] <= {quo_in[DIV_STEPS-2:0], ge};
                tag_reg[i] <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];
    assign quo       = quo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> hw/rtl/ctrgb_matrix.sv
`default_nettype none

module ctrgb_matrix
    import ctrgb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire logic [DIV_STEPS-1:0] xq,
    input  wire logic [DIV_STEPS-1:0] zmag,
    input  wire logic                 zneg,
    output logic                      out_valid,
    output logic [OUT_W-1:0]          red,
    output logic [OUT_W-1:0]          green,
    output logic [OUT_W-1:0]          blue
);

    logic                    vld1_reg, vld2_reg, vld3_reg;
    logic signed [XYZ_W-1:0] xyz [3];
    logic signed [XYZ_W-1:0] zm;
    logic signed [ACC_W-1:0] prod_reg [9];
    logic signed [ACC_W-1:0] prod_next [9];
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] acc_next [3];
    logic [OUT_W-1:0]        out_reg [3];
    logic [OUT_W-1:0]        out_next [3];

    // round to nearest, ties away from zero, then saturate
    function automatic logic [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic             neg;
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] rnd;
        neg = acc[ACC_W-1];
        mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
        rnd = (mag + (ACC_W'(1) << (RND_SH - 1))) >> RND_SH;
        if (neg) begin
            if (rnd > (ACC_W'(1) << (OUT_W - 1))) begin
                rnd = ACC_W'(1) << (OUT_W - 1);
            end
            round_sat = OUT_W'(ACC_W'(0) - rnd);
        end else begin
            if (rnd > ((ACC_W'(1) << (OUT_W - 1)) - ACC_W'(1))) begin
                rnd = (ACC_W'(1) << (OUT_W - 1)) - ACC_W'(1);
            end
            round_sat = OUT_W'(rnd);
        end
    endfunction

    // xyz vector and products
    always_comb begin
        zm     = signed'(XYZ_W'(zmag));
        xyz[0] = signed'(XYZ_W'(xq));
        xyz[1] = signed'(XYZ_W'(1) << UV_SHIFT);
        xyz[2] = zneg ? -zm : zm;
        for (int i = 0; i < 9; i++) begin
            prod_next[i] = ACC_W'(MAT[i]) * ACC_W'(xyz[i % 3]);
        end
    end

    // channel sums and final rounding
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc_next[c] = prod_reg[3*c] + prod_reg[3*c+1] + prod_reg[3*c+2];
            out_next[c] = round_sat(acc_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (ce) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            out_reg  <= out_next;
        end
    end

    assign out_valid = vld3_reg;
    assign red       = out_reg[0];
    assign green     = out_reg[1];
    assign blue      = out_reg[2];

endmodule

`default_nettype wire

>>> tb/tb_color_temperature_to_rgb_unit.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_color_temperature_to_rgb_unit;
    import ctrgb_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_t;

    // one directed row: temperature, and where the clamp makes the answer obvious,
    // the in-range temperature whose color it must equal
    typedef struct {
        logic [IN_W-1:0] kelvin;
        bit              same_as_clamp;
        logic [IN_W-1:0] clamp_kelvin;
    } kelvin_row_t;

    localparam int N_RANDOM = 1330;
    localparam int SETTLE   = 200;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [IN_W-1:0]     s_temperature_kelvin;
    logic                m_valid;
    logic                m_ready;
    logic [OUT_W-1:0]    m_red;
    logic [OUT_W-1:0]    m_green;
    logic [OUT_W-1:0]    m_blue;

    rgb_t        expected_colors[$];
    int          errors;
    int          burst_left;
    kelvin_row_t kelvin_rows[$];

    color_temperature_to_rgb_unit DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_temperature_kelvin (s_temperature_kelvin),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_red                (m_red),
        .m_green              (m_green),
        .m_blue               (m_blue)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor(num * 2^bits / den), zero for a zero divisor
    function automatic logic [127:0] frac_div(logic [127:0] num, logic [127:0] den, int bits);
        if (den == 0)
            return 128'd0;
        return (num << bits) / den;
    endfunction

    // decimal constant m / p10 scaled by 2^s, rounded to nearest
    function automatic logic [127:0] fix_const(logic [127:0] m, logic [127:0] p10, int s);
        return (frac_div(m, p10, s + 1) + 128'd1) >> 1;
    endfunction

    // round a Q.56 channel sum to the output format and saturate
    function automatic logic [OUT_W-1:0] round_channel(longint acc);
        logic            neg;
        logic [63:0]     mag;
        int              sh;
        neg = acc < 0;
        mag = neg ? 64'(-acc) : 64'(acc);
        sh  = UV_SHIFT + MAT_SHIFT - FRAC_BITS;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (neg) begin
            if (mag > 64'd2097152)
                mag = 64'd2097152;
            return OUT_W'(-mag);
        end
        if (mag > 64'd2097151)
            mag = 64'd2097151;
        return OUT_W'(mag);
    endfunction

    // black-body color for one temperature
    function automatic rgb_t locus_color(logic [IN_W-1:0] kelvin);
        logic [127:0]        t, t2, one, nu, du, nv, dv, uq, vq, xq, zabs, zmag;
        logic signed [127:0] zn;
        longint              xyz[3];
        longint              acc, c;
        logic [OUT_W-1:0]    chan[3];
        logic [63:0]         mant[9];
        bit                  neg[9];
        mant = '{64'd32404542, 64'd15371385, 64'd4985314,
                 64'd9692660, 64'd18760108, 64'd415560,
                 64'd556434, 64'd2040259, 64'd10572252};
        neg  = '{0, 1, 1, 1, 0, 0, 0, 1, 0};
        t = 128'(kelvin);
        if (t < 128'd1000)
            t = 128'd1000;
        if (t > 128'd15000)
            t = 128'd15000;
        t2  = t * t;
        one = 128'd1 << 48;
        nu = fix_const(128'd860117757, 128'd1000000000, 48)
           + fix_const(128'd154118254, 128'd1000000000000, 48) * t
           + fix_const(128'd128641212, 128'd1000000000000000, 48) * t2;
        du = one
           + fix_const(128'd842420235, 128'd1000000000000, 48) * t
           + fix_const(128'd708145163, 128'd1000000000000000, 48) * t2;
        nv = fix_const(128'd317398726, 128'd1000000000, 48)
           + fix_const(128'd422806245, 128'd10000000000000, 48) * t
           + fix_const(128'd420481691, 128'd10000000000000000, 48) * t2;
        dv = one
           + fix_const(128'd161456053, 128'd1000000000000000, 48) * t2
           - fix_const(128'd289741816, 128'd10000000000000, 48) * t;
        uq = frac_div(nu, du, 32);
        vq = frac_div(nv, dv, 32);
        xq = frac_div(3 * uq, 2 * vq, 32);
        zn = $signed(128'd4 << 32) - $signed(uq) - $signed(10 * vq);
        zabs = zn < 0 ? 128'(-zn) : 128'(zn);
        zmag = frac_div(zabs, 2 * vq, 32);
        xyz[0] = longint'(xq);
        xyz[1] = longint'(64'd1 << 32);
        xyz[2] = zn < 0 ? -longint'(zmag) : longint'(zmag);
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
                c = longint'(fix_const(128'(mant[ch*3+k]), 128'd10000000, 24));
                if (neg[ch*3+k])
                    c = -c;
                acc += c * xyz[k];
            end
            chan[ch] = round_channel(acc);
        end
        return '{red: chan[0], green: chan[1], blue: chan[2]};
    endfunction

    // record the expected color at each input transfer
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_colors.push_back(locus_color(s_temperature_kelvin));
    end

    // compare each output transfer with the oldest expectation
    always @(posedge aclk) begin
        rgb_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result r=%h g=%h b=%h", $time, m_red, m_green, m_blue);
                errors++;
            end else begin
                exp_c = expected_colors.pop_front();
                if (m_red !== exp_c.red) begin
                    $display("%0t: red expected %h actual %h", $time, exp_c.red, m_red);
                    errors++;
                end
                if (m_green !== exp_c.green) begin
                    $display("%0t: green expected %h actual %h", $time, exp_c.green, m_green);
                    errors++;
                end
                if (m_blue !== exp_c.blue) begin
                    $display("%0t: blue expected %h actual %h", $time, exp_c.blue, m_blue);
                    errors++;
                end
            end
        end
    end

    // receiver stalls: modes change every so often, including no stalls at all
    always @(posedge aclk) begin
        int mode;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            mode = int'(($time / 2000) % 4);
            case (mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 1) == 1);
                end
                2: begin
                    m_ready <= ($urandom_range(0, 9) == 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 9) != 0);
                end
            endcase
        end
    end

    // present one temperature, after an idle gap before some bursts, and hold it until the transfer
    task automatic send_kelvin(logic [IN_W-1:0] kelvin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_temperature_kelvin <= kelvin;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        burst_left--;
    endtask

    function automatic kelvin_row_t row(logic [IN_W-1:0] k, bit clamped, logic [IN_W-1:0] ck);
        return '{kelvin: k, same_as_clamp: clamped, clamp_kelvin: ck};
    endfunction

    // stimulus
    initial begin
        logic [IN_W-1:0] k;
        int              pick;
        errors               = 0;
        burst_left           = 0;
        aresetn              = 1'b0;
        s_valid              = 1'b0;
        s_temperature_kelvin = '0;

        kelvin_rows = '{
            row(16'd0,     1, 16'd1000),  row(16'd1,     1, 16'd1000),
            row(16'd999,   1, 16'd1000),  row(16'd1000,  0, 16'd0),
            row(16'd1001,  0, 16'd0),     row(16'd1500,  0, 16'd0),
            row(16'd2700,  0, 16'd0),     row(16'd4000,  0, 16'd0),
            row(16'd5000,  0, 16'd0),     row(16'd6500,  0, 16'd0),
            row(16'd6504,  0, 16'd0),     row(16'd9300,  0, 16'd0),
            row(16'd12000, 0, 16'd0),     row(16'd14999, 0, 16'd0),
            row(16'd15000, 0, 16'd0),     row(16'd15001, 1, 16'd15000),
            row(16'h5555,  1, 16'd15000), row(16'hAAAA,  1, 16'd15000),
            row(16'h8000,  1, 16'd15000), row(16'hFFFF,  1, 16'd15000),
            row(16'h7FFF,  1, 16'd15000), row(16'd1000,  0, 16'd0)
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; clamped temperatures must match their limit
        foreach (kelvin_rows[i]) begin
            if (kelvin_rows[i].same_as_clamp &&
                locus_color(kelvin_rows[i].kelvin) !== locus_color(kelvin_rows[i].clamp_kelvin)) begin
                $display("%0t: clamp of %0d expected %h actual %h", $time, kelvin_rows[i].kelvin,
                         locus_color(kelvin_rows[i].clamp_kelvin),
                         locus_color(kelvin_rows[i].kelvin));
                errors++;
            end
            send_kelvin(kelvin_rows[i].kelvin);
        end

        // random: mostly in range, some below, above, near either limit and anywhere
        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                k = IN_W'($urandom_range(1000, 15000));
            else if (pick < 78)
                k = IN_W'($urandom_range(0, 999));
            else if (pick < 86)
                k = IN_W'($urandom_range(15001, 65535));
            else if (pick < 92)
                k = IN_W'($urandom_range(990, 1010) + (($urandom_range(0, 1) == 1) ? 14000 : 0));
            else
                k = IN_W'($urandom());
            send_kelvin(k);
        end
        s_valid <= 1'b0;

        while (expected_colors.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // timeout
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
